// ===== src/ffca_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and field widths of the first-fit chunk allocator.
// Used by the controller, the datapath, the top level and the checker.
package ffca_pkg;

    localparam int DATA_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;
    localparam logic [DATA_W-1:0] WRITABLE_RESET = 16'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_CONSTANTS_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITABLE_SIZE = 1'b1;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE = 2'd1;
    localparam logic [1:0] MODE_REBUILD = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_FIT = 2'd1;
    localparam logic [1:0] ST_BAD_HANDLE = 2'd2;
    localparam logic [1:0] ST_TOO_BIG = 2'd3;

    typedef logic [3:0] op_t;
    localparam op_t OP_NONE = 4'd0;
    localparam op_t OP_LOAD = 4'd1;
    localparam op_t OP_SCAN = 4'd2;
    localparam op_t OP_SHIFT_RD = 4'd3;
    localparam op_t OP_SHIFT_WR = 4'd4;
    localparam op_t OP_SPLIT_WR = 4'd5;
    localparam op_t OP_HIT_WR = 4'd6;
    localparam op_t OP_FREE_WR = 4'd7;
    localparam op_t OP_REB0 = 4'd8;
    localparam op_t OP_REB1 = 4'd9;
    localparam op_t OP_OUT = 4'd10;

    typedef struct packed {
        logic [DATA_W-1:0] payload;
        logic taken;
        logic fixed;
    } entry_t;

    typedef struct packed {
        op_t op;
        logic res_set;
        logic [1:0] res_status;
        logic res_hsel;
    } dp_cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic hit;
        logic miss;
        logic fixed;
        logic split;
        logic shift_done;
        logic too_big;
        logic out_busy;
    } dp_stat_t;

endpackage

// ===== src/ffca_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the first-fit chunk allocator.
// Depends on ffca_pkg; drives the datapath through dp_cmd_t.
module ffca_ctrl
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    input  logic [1:0] mode,
    output logic s_tready,
    input  ffca_pkg::dp_stat_t stat,
    output ffca_pkg::dp_cmd_t cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_FIT = 4'd2;
    localparam logic [3:0] S_SHIFT_RD = 4'd3;
    localparam logic [3:0] S_SHIFT_WR = 4'd4;
    localparam logic [3:0] S_SPLIT = 4'd5;
    localparam logic [3:0] S_HIT = 4'd6;
    localparam logic [3:0] S_FREE = 4'd7;
    localparam logic [3:0] S_REB0 = 4'd8;
    localparam logic [3:0] S_REB1 = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op = ffca_pkg::OP_NONE;
        cmd.res_set = 1'b0;
        cmd.res_status = ffca_pkg::ST_OK;
        cmd.res_hsel = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op = ffca_pkg::OP_LOAD;
                    unique case (mode)
                        ffca_pkg::MODE_ALLOC, ffca_pkg::MODE_FREE:
                        begin
                            state_next = S_SCAN;
                        end
                        ffca_pkg::MODE_REBUILD:
                        begin
                            if (stat.too_big)
                            begin
                                cmd.res_set = 1'b1;
                                cmd.res_status = ffca_pkg::ST_TOO_BIG;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_REB0;
                            end
                        end
                        default:
                        begin
                            cmd.res_set = 1'b1;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.op = ffca_pkg::OP_SCAN;
                if (stat.hit)
                begin
                    state_next = stat.is_alloc ? S_FIT : S_FREE;
                end
                else if (stat.miss)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_status = stat.is_alloc ? ffca_pkg::ST_NO_FIT
                                                   : ffca_pkg::ST_BAD_HANDLE;
                    state_next = S_DONE;
                end
            end
            S_FIT:
            begin
                priority if (!stat.split)
                begin
                    state_next = S_HIT;
                end
                else if (stat.shift_done)
                begin
                    state_next = S_SPLIT;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.op = ffca_pkg::OP_SHIFT_RD;
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                cmd.op = ffca_pkg::OP_SHIFT_WR;
                state_next = S_FIT;
            end
            S_SPLIT:
            begin
                cmd.op = ffca_pkg::OP_SPLIT_WR;
                state_next = S_HIT;
            end
            S_HIT:
            begin
                cmd.op = ffca_pkg::OP_HIT_WR;
                cmd.res_set = 1'b1;
                cmd.res_hsel = 1'b1;
                state_next = S_DONE;
            end
            S_FREE:
            begin
                cmd.op = ffca_pkg::OP_FREE_WR;
                cmd.res_set = 1'b1;
                cmd.res_status = stat.fixed ? ffca_pkg::ST_BAD_HANDLE : ffca_pkg::ST_OK;
                state_next = S_DONE;
            end
            S_REB0:
            begin
                cmd.op = ffca_pkg::OP_REB0;
                state_next = S_REB1;
            end
            S_REB1:
            begin
                cmd.op = ffca_pkg::OP_REB1;
                cmd.res_set = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op = ffca_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/ffca_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the first-fit chunk allocator: chunk table memory, offset walk,
// configuration registers and the output register. Depends on ffca_pkg.
module ffca_dp
#(
    parameter int MAX_CHUNKS = 64,
    parameter int HEADER_BYTES = 16,
    parameter int HEAP_BYTES = 65536
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic [1:0] mode,
    input  logic [ffca_pkg::DATA_W-1:0] request_bytes,
    input  logic [ffca_pkg::DATA_W-1:0] handle_in,
    input  logic cfg_we,
    input  logic [ffca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ffca_pkg::DATA_W-1:0] cfg_data,
    input  ffca_pkg::dp_cmd_t cmd,
    output ffca_pkg::dp_stat_t stat,
    input  logic m_tready,
    output logic m_tvalid,
    output logic [ffca_pkg::DATA_W-1:0] handle_out,
    output logic [1:0] status
);

    localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int HW = $clog2(HEAP_BYTES + 1);
    localparam int OW = (HW > 18) ? HW : 18;
    localparam int DW = ffca_pkg::DATA_W;

    ffca_pkg::entry_t mem [MAX_CHUNKS];
    ffca_pkg::entry_t rd_data_reg;
    ffca_pkg::entry_t hit_ent_reg;
    ffca_pkg::entry_t wdata;
    logic we;
    logic re;
    logic [IW-1:0] waddr;
    logic [IW-1:0] raddr;

    logic [DW-1:0] cl_reg;
    logic [DW-1:0] ws_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] ptr_reg;
    logic chk_valid_reg;
    logic alloc_reg;
    logic out_valid_reg;
    logic [DW-1:0] req_reg;
    logic [DW-1:0] h_reg;
    logic [IW-1:0] chk_idx_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [CW-1:0] k_reg;
    logic [OW-1:0] offset_reg;
    logic [DW-1:0] hit_off_reg;
    logic [DW-1:0] res_handle_reg;
    logic [1:0] res_status_reg;
    logic [DW-1:0] out_handle_reg;
    logic [1:0] out_status_reg;

    logic [OW:0] total;
    logic [OW-1:0] h_ext;
    logic fit;
    logic match;
    logic over;
    logic [CW-1:0] k_dec;
    logic [CW-1:0] idx_inc;
    logic [DW-1:0] leftover;

    assign total = (OW + 1)'(2 * HEADER_BYTES) + (OW + 1)'(cl_reg) + (OW + 1)'(ws_reg);
    assign h_ext = OW'(h_reg);
    assign fit = (rd_data_reg.payload >= req_reg) && !rd_data_reg.taken && !rd_data_reg.fixed;
    assign match = (offset_reg == h_ext);
    assign over = (offset_reg > h_ext);
    assign k_dec = k_reg - CW'(1);
    assign idx_inc = CW'(hit_idx_reg) + CW'(1);
    assign leftover = hit_ent_reg.payload - DW'(HEADER_BYTES) - req_reg;

    assign stat.is_alloc = alloc_reg;
    assign stat.hit = chk_valid_reg && (alloc_reg ? fit : match);
    assign stat.miss = (chk_valid_reg && !alloc_reg && over)
                       || (!chk_valid_reg && (ptr_reg >= count_reg));
    assign stat.fixed = hit_ent_reg.fixed;
    assign stat.split = ({2'b00, hit_ent_reg.payload}
                         > ({2'b00, req_reg} + 18'(HEADER_BYTES)))
                        && (count_reg < CW'(MAX_CHUNKS));
    assign stat.shift_done = (k_reg <= idx_inc);
    assign stat.too_big = (total > (OW + 1)'(HEAP_BYTES));
    assign stat.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign handle_out = out_handle_reg;
    assign status = out_status_reg;

    always_comb
    begin
        we = 1'b0;
        re = 1'b0;
        waddr = hit_idx_reg;
        raddr = ptr_reg[IW-1:0];
        wdata = hit_ent_reg;
        unique case (cmd.op)
            ffca_pkg::OP_SCAN:
            begin
                re = (ptr_reg < count_reg);
            end
            ffca_pkg::OP_SHIFT_RD:
            begin
                re = 1'b1;
                raddr = k_dec[IW-1:0];
            end
            ffca_pkg::OP_SHIFT_WR:
            begin
                we = 1'b1;
                waddr = k_reg[IW-1:0];
                wdata = rd_data_reg;
            end
            ffca_pkg::OP_SPLIT_WR:
            begin
                we = 1'b1;
                waddr = idx_inc[IW-1:0];
                wdata = '{payload: leftover, taken: 1'b0, fixed: 1'b0};
            end
            ffca_pkg::OP_HIT_WR:
            begin
                we = 1'b1;
                wdata = '{payload: stat.split ? req_reg : hit_ent_reg.payload,
                          taken: 1'b1, fixed: 1'b0};
            end
            ffca_pkg::OP_FREE_WR:
            begin
                we = !hit_ent_reg.fixed;
                wdata = '{payload: hit_ent_reg.payload, taken: 1'b0, fixed: 1'b0};
            end
            ffca_pkg::OP_REB0:
            begin
                we = 1'b1;
                waddr = IW'(0);
                wdata = '{payload: cl_reg, taken: 1'b1, fixed: 1'b1};
            end
            ffca_pkg::OP_REB1:
            begin
                we = 1'b1;
                waddr = IW'(1);
                wdata = '{payload: ws_reg, taken: 1'b0, fixed: 1'b0};
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cl_reg <= '0;
            ws_reg <= ffca_pkg::WRITABLE_RESET;
            count_reg <= '0;
            ptr_reg <= '0;
            chk_valid_reg <= 1'b0;
            alloc_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == ffca_pkg::CFG_CONSTANTS_LENGTH)
                begin
                    cl_reg <= cfg_data;
                end
                else
                begin
                    ws_reg <= cfg_data;
                end
            end
            if (cmd.op == ffca_pkg::OP_LOAD)
            begin
                ptr_reg <= '0;
                chk_valid_reg <= 1'b0;
                alloc_reg <= (mode == ffca_pkg::MODE_ALLOC);
            end
            else if (cmd.op == ffca_pkg::OP_SCAN)
            begin
                chk_valid_reg <= re;
                if (re)
                begin
                    ptr_reg <= ptr_reg + CW'(1);
                end
            end
            if (cmd.op == ffca_pkg::OP_HIT_WR && stat.split)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.op == ffca_pkg::OP_REB1)
            begin
                count_reg <= CW'(2);
            end
            if (cmd.op == ffca_pkg::OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == ffca_pkg::OP_LOAD)
        begin
            req_reg <= request_bytes;
            h_reg <= handle_in;
            offset_reg <= '0;
        end
        else if (cmd.op == ffca_pkg::OP_SCAN && chk_valid_reg)
        begin
            chk_idx_reg <= raddr;
            hit_idx_reg <= chk_idx_reg;
            hit_ent_reg <= rd_data_reg;
            hit_off_reg <= offset_reg[DW-1:0];
            k_reg <= count_reg;
            offset_reg <= offset_reg + OW'(HEADER_BYTES) + OW'(rd_data_reg.payload);
        end
        else if (cmd.op == ffca_pkg::OP_SCAN)
        begin
            chk_idx_reg <= raddr;
        end
        if (cmd.op == ffca_pkg::OP_SHIFT_WR)
        begin
            k_reg <= k_dec;
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_handle_reg <= cmd.res_hsel ? hit_off_reg : '0;
        end
        if (cmd.op == ffca_pkg::OP_OUT)
        begin
            out_handle_reg <= res_handle_reg;
            out_status_reg <= res_status_reg;
        end
    end

endmodule

// ===== src/first_fit_chunk_allocator_unit.sv =====
`timescale 1ns / 1ps
// An allocate or a free walks the chunk table one entry per cycle through a
// single read port of the table memory. An allocate that fits marks its chunk
// taken and hands out its offset; a free that finds its chunk clears it unless
// it is fixed. A walk ends when it runs off the table, and a free ends when it
// passes the handle. A split first moves each later chunk up one place, a read
// and then a write per chunk, and then writes the leftover chunk. A rebuild
// that fits writes the two table entries; a refused rebuild and any other item
// go straight to the result. One item is worked at a time; a finished result
// waits in the output register while the next item is accepted.
// Top level; depends on ffca_pkg, ffca_ctrl and ffca_dp.
module first_fit_chunk_allocator_unit
#(
    parameter int MAX_CHUNKS = 64,
    parameter int HEADER_BYTES = 16,
    parameter int HEAP_BYTES = 65536
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [ffca_pkg::S_TDATA_W-1:0] s_tdata, // request_bytes, handle_in
    input  logic [1:0] s_tuser,                     // mode
    output logic m_tvalid,
    input  logic m_tready,
    output logic [ffca_pkg::M_TDATA_W-1:0] m_tdata, // handle_out, status, zero fill
    input  logic cfg_we,
    input  logic [ffca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ffca_pkg::DATA_W-1:0] cfg_data
);

    ffca_pkg::dp_cmd_t cmd;
    ffca_pkg::dp_stat_t stat;
    logic [ffca_pkg::DATA_W-1:0] handle_out;
    logic [1:0] status;

    assign m_tdata = {6'b000000, status, handle_out};

    ffca_ctrl u_ctrl
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .mode(s_tuser),
        .s_tready(s_tready),
        .stat(stat),
        .cmd(cmd)
    );

    ffca_dp
    #(
        .MAX_CHUNKS(MAX_CHUNKS),
        .HEADER_BYTES(HEADER_BYTES),
        .HEAP_BYTES(HEAP_BYTES)
    )
    u_dp
    (
        .clk(clk),
        .rst_n(rst_n),
        .mode(s_tuser),
        .request_bytes(s_tdata[15:0]),
        .handle_in(s_tdata[31:16]),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cmd(cmd),
        .stat(stat),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .handle_out(handle_out),
        .status(status)
    );

endmodule

// ===== src/ffca_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the first-fit chunk allocator, bound to the top level.
// Depends on ffca_pkg.
module ffca_checker
(
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [ffca_pkg::M_TDATA_W-1:0] m_tdata
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[17:16] != ffca_pkg::ST_OK) |-> (m_tdata[15:0] == 16'd0))
        else $error("failed item carries a nonzero handle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken before the first finished");

    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:18] == 6'd0))
        else $error("result fill bits not zero");

endmodule

bind first_fit_chunk_allocator_unit ffca_checker u_ffca_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

// ===== bench/first_fit_chunk_allocator_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the first-fit chunk allocator: a heap table model
// predicts each result and a small scoreboard compares the output items.
// Depends on ffca_pkg and first_fit_chunk_allocator_unit.

class alloc_scoreboard;
    logic [15:0] want_handle[$];
    logic [1:0] want_status[$];
    int errors;

    function void note_request(logic [15:0] h, logic [1:0] st);
        want_handle.push_back(h);
        want_status.push_back(st);
    endfunction

    task report(string msg);
        $display("%s", msg);
        errors++;
    endtask

    task check_result(logic [15:0] h, logic [1:0] st);
        logic [15:0] eh;
        logic [1:0] es;
        if (want_handle.size() == 0)
        begin
            report($sformatf("unexpected result handle %0d status %0d", h, st));
            return;
        end
        eh = want_handle.pop_front();
        es = want_status.pop_front();
        if (eh !== h)
        begin
            report($sformatf("handle mismatch: got %0d want %0d", h, eh));
        end
        if (es !== st)
        begin
            report($sformatf("status mismatch: got %0d want %0d", st, es));
        end
    endtask

    function int pending();
        return want_handle.size();
    endfunction
endclass

module first_fit_chunk_allocator_unit_test;
    import ffca_pkg::*;

    localparam int NCH = 64;
    localparam int HDR = 16;
    localparam int HEAP = 65536;
    localparam int WATCH_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;

    first_fit_chunk_allocator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    alloc_scoreboard board;

    logic [15:0] const_len;
    logic [15:0] free_len;
    int unsigned sizes[NCH];
    bit taken[NCH];
    bit fixed[NCH];
    int unsigned count;
    int unsigned live_handles[$];
    int watchdog;
    int rx_wait;
    bit done;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [1:0] heap_rebuild();
        if (2 * HDR + 32'(const_len) + 32'(free_len) > HEAP)
            return ST_TOO_BIG;
        sizes[0] = 32'(const_len);
        taken[0] = 1;
        fixed[0] = 1;
        sizes[1] = 32'(free_len);
        taken[1] = 0;
        fixed[1] = 0;
        count = 2;
        return ST_OK;
    endfunction

    function automatic logic [1:0] table_alloc(int unsigned req, output logic [15:0] h);
        int unsigned offs;
        int unsigned pay;
        offs = 0;
        h = '0;
        for (int i = 0; i < count; i++)
        begin
            pay = sizes[i];
            if (pay >= req && !taken[i] && !fixed[i])
            begin
                taken[i] = 1;
                if (pay > req + HDR && count < NCH)
                begin
                    for (int k = count; k > i + 1; k--)
                    begin
                        sizes[k] = sizes[k-1];
                        taken[k] = taken[k-1];
                        fixed[k] = fixed[k-1];
                    end
                    sizes[i+1] = pay - HDR - req;
                    taken[i+1] = 0;
                    fixed[i+1] = 0;
                    sizes[i] = req;
                    count++;
                end
                h = offs[15:0];
                return ST_OK;
            end
            offs += HDR + pay;
        end
        return ST_NO_FIT;
    endfunction

    function automatic logic [1:0] table_release(int unsigned h);
        int unsigned offs;
        offs = 0;
        for (int i = 0; i < count; i++)
        begin
            if (offs == h)
            begin
                if (fixed[i])
                    return ST_BAD_HANDLE;
                taken[i] = 0;
                return ST_OK;
            end
            if (offs > h)
                break;
            offs += HDR + sizes[i];
        end
        return ST_BAD_HANDLE;
    endfunction

    task automatic send_request(logic [1:0] mode, logic [15:0] req, logic [15:0] hin);
        logic [15:0] h;
        logic [1:0] st;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {hin, req};
        do
            @(posedge clk);
        while (!s_tready);
        h = '0;
        st = ST_OK;
        case (mode)
            MODE_ALLOC:
            begin
                st = table_alloc(32'(req), h);
                if (st == ST_OK)
                    live_handles.push_back(32'(h));
            end
            MODE_FREE: st = table_release(32'(hin));
            MODE_REBUILD:
            begin
                st = heap_rebuild();
                if (st == ST_OK)
                    live_handles.delete();
            end
            default: ;
        endcase
        board.note_request(h, st);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (board.pending() != 0 && guard < WATCH_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_CONSTANTS_LENGTH)
            const_len = val;
        else
            free_len = val;
    endtask

    task automatic random_request();
        int r;
        logic [15:0] hin;
        r = $urandom_range(0, 99);
        if (r < 50)
            send_request(MODE_ALLOC, ($urandom_range(0, 9) == 0) ? 16'($urandom)
                         : 16'($urandom_range(0, 300)), 16'($urandom));
        else if (r < 88)
        begin
            if (live_handles.size() != 0 && $urandom_range(0, 4) != 0)
                hin = 16'(live_handles[$urandom_range(0, live_handles.size() - 1)]);
            else
                hin = 16'($urandom);
            send_request(MODE_FREE, 16'($urandom), hin);
        end
        else if (r < 92)
            send_request(MODE_REBUILD, 16'($urandom), 16'($urandom));
        else if (r < 94)
            send_request(MODE_NONE, 16'($urandom), 16'($urandom));
        else
            send_request(MODE_ALLOC, 16'($urandom_range(0, 40)), 16'($urandom));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                board.check_result(m_tdata[15:0], m_tdata[17:16]);
                rx_wait = $urandom_range(0, 8);
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || done)
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCH_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] cfgs[5][2];
        board = new();
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = MODE_ALLOC;
        m_tready = 0;
        cfg_we = 0;
        cfg_index = CFG_CONSTANTS_LENGTH;
        cfg_data = '0;
        const_len = 0;
        free_len = WRITABLE_RESET;
        count = 0;
        watchdog = 0;
        rx_wait = 0;
        done = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(MODE_ALLOC, 16'd0, 16'd0);
        send_request(MODE_FREE, 16'd0, 16'd0);
        send_request(MODE_NONE, 16'hFFFF, 16'hFFFF);
        send_request(MODE_REBUILD, 16'd0, 16'd0);
        send_request(MODE_FREE, 16'd0, 16'd0);
        send_request(MODE_ALLOC, 16'd0, 16'd0);
        send_request(MODE_ALLOC, 16'd100, 16'd0);
        send_request(MODE_FREE, 16'd0, 16'd16);
        send_request(MODE_FREE, 16'd0, 16'd16);
        send_request(MODE_FREE, 16'd0, 16'd17);
        send_request(MODE_ALLOC, 16'hFFFF, 16'hFFFF);
        send_request(MODE_ALLOC, 16'd4000, 16'd0);
        drain();
        write_reg(CFG_CONSTANTS_LENGTH, 16'hFFFF);
        write_reg(CFG_WRITABLE_SIZE, 16'hFFFF);
        send_request(MODE_REBUILD, 16'd0, 16'd0);
        send_request(MODE_ALLOC, 16'd10, 16'd0);
        drain();
        write_reg(CFG_CONSTANTS_LENGTH, 16'd0);
        write_reg(CFG_WRITABLE_SIZE, 16'd65504);
        send_request(MODE_REBUILD, 16'd0, 16'd0);
        send_request(MODE_ALLOC, 16'd65504, 16'd0);
        send_request(MODE_FREE, 16'd0, 16'd16);
        drain();

        cfgs = '{'{16'd0, 16'd4096}, '{16'd65000, 16'd400}, '{16'd7, 16'd2000},
                 '{16'd32768, 16'd32700}, '{16'd100, 16'd0}};
        for (int p = 0; p < 5; p++)
        begin
            write_reg(CFG_CONSTANTS_LENGTH, cfgs[p][0]);
            write_reg(CFG_WRITABLE_SIZE, cfgs[p][1]);
            send_request(MODE_REBUILD, 16'($urandom), 16'($urandom));
            for (int n = 0; n < 400; n++)
            begin
                random_request();
                if (n == 200 && p == 2)
                    drain();
            end
            drain();
        end
        done = 1;
        if (board.errors == 0 && board.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
src/ffca_pkg.sv
src/ffca_ctrl.sv
src/ffca_dp.sv
src/first_fit_chunk_allocator_unit.sv
src/ffca_checker.sv
bench/first_fit_chunk_allocator_unit_test.sv
